// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain implication check
`define CHK_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// next-cycle implication check
`define CHK_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);

`endif

// ===== rtl/core/cwcm_pkg.sv =====
// ----------------------------------------------------------------------------
// cwcm_pkg
// Types, register indexes and digit-step functions of the cylindrical warp map.
// ----------------------------------------------------------------------------
package cwcm_pkg;

	// register indexes
	localparam logic [2:0] REG_RADIUS     = 3'd0;
	localparam logic [2:0] REG_WIDTH      = 3'd1;
	localparam logic [2:0] REG_HEIGHT     = 3'd2;
	localparam logic [2:0] REG_COL_OFFSET = 3'd3;
	localparam logic [2:0] REG_ROW_OFFSET = 3'd4;

	localparam logic [23:0] RADIUS_RST   = 24'd172204;
	localparam logic [12:0] WIDTH_RST    = 13'd640;
	localparam logic [12:0] HEIGHT_RST   = 13'd480;

	// square root: 50-bit radicand, 25 root bits, 5 bits per stage
	localparam int SQ_N   = 25;
	localparam int SQ_PER = 5;
	localparam int SQ_ST  = (SQ_N + SQ_PER - 1) / SQ_PER;

	// divide: 41 quotient bits, 6 per stage
	localparam int DIV_N   = 41;
	localparam int DIV_PER = 6;
	localparam int DIV_ST  = (DIV_N + DIV_PER - 1) / DIV_PER;

	typedef struct packed {
		logic [11:0] column;
		logic [11:0] row;
	} pix_t;

	typedef struct packed {
		logic        in_bounds;
		logic [19:0] source_x_q8;
		logic [19:0] source_y_q8;
		logic [26:0] dest_index;
	} map_t;

	// per-word values carried down the pipe
	typedef struct packed {
		logic        sx;
		logic [19:0] adx;
		logic        sy;
		logic [19:0] ady;
		logic [26:0] idx;
	} side_t;

	typedef struct packed {
		logic [49:0] v;
		logic [27:0] rem;
		logic [24:0] q;
	} sq_st_t;

	typedef struct packed {
		logic [40:0] num;
		logic [23:0] rem;
		logic [40:0] q;
	} dv_st_t;

	// one restoring square-root digit
	function automatic sq_st_t sqrt_step(sq_st_t a);
		sq_st_t      b;
		logic [27:0] t;
		logic [27:0] tr;
		t  = {a.rem[25:0], a.v[49:48]};
		tr = {1'b0, a.q, 2'b01};
		if (t >= tr) begin
			b.rem = t - tr;
			b.q   = {a.q[23:0], 1'b1};
		end else begin
			b.rem = t;
			b.q   = {a.q[23:0], 1'b0};
		end
		b.v = {a.v[47:0], 2'b00};
		return b;
	endfunction

	// one restoring division digit
	function automatic dv_st_t div_step(dv_st_t a, logic [23:0] d);
		dv_st_t      b;
		logic [24:0] t;
		logic [24:0] diff;
		t    = {a.rem, a.num[40]};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			b.rem = diff[23:0];
			b.q   = {a.q[39:0], 1'b1};
		end else begin
			b.rem = t[23:0];
			b.q   = {a.q[39:0], 1'b0};
		end
		b.num = {a.num[39:0], 1'b0};
		return b;
	endfunction

endpackage

// ===== rtl/core/cylindrical_warp_coord_map.sv =====
// ----------------------------------------------------------------------------
// cylindrical_warp_coord_map
// Inverse cylindrical projection of destination pixels to source coordinates.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one word per clock. The pipe has 18
// register stages; the first loads on the accepting edge, and the mapped word
// shows on map from the last stage. The pipe holds the square-root chain (5
// stages, 5 root bits each) and the restoring divider (41 quotient bits over 7
// stages, up to 6 per stage); the whole pipe moves as one and stalls only when
// the output word is held. Registers must be written while the pipe is empty.
module cylindrical_warp_coord_map #(
	parameter int MAX_DIM = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_wdata,
	input  logic               pix_valid,
	output logic               pix_ready,
	input  cwcm_pkg::pix_t     pix,
	output logic               map_valid,
	input  logic               map_ready,
	output cwcm_pkg::map_t     map
);
	import cwcm_pkg::*;

	localparam logic [13:0] DIM_MAX_C = 14'(MAX_DIM);

	logic [23:0] radius_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [11:0] col_off_q;
	logic [12:0] row_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			col_off_q <= '0;
			row_off_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS:     radius_q  <= cfg_wdata;
				REG_WIDTH:      width_q   <= cfg_wdata[12:0];
				REG_HEIGHT:     height_q  <= cfg_wdata[12:0];
				REG_COL_OFFSET: col_off_q <= cfg_wdata[11:0];
				REG_ROW_OFFSET: row_off_q <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	logic [13:0] w;
	logic [13:0] h;
	assign w = ({1'b0, width_q}  > DIM_MAX_C) ? DIM_MAX_C : {1'b0, width_q};
	assign h = ({1'b0, height_q} > DIM_MAX_C) ? DIM_MAX_C : {1'b0, height_q};

	logic adv;
	logic v_s8;
	assign adv       = !v_s8 || map_ready;
	assign pix_ready = adv;

	// ---------------- s1: offsets from center, destination index
	logic [21:0] dx, dy, ndx, ndy;
	logic [13:0] rsum;
	logic [14:0] csum;
	logic [28:0] idx_prod, idx_sum;

	assign dx       = {2'b00, pix.column, 8'd0} - {1'b0, w, 7'd0};
	assign dy       = {2'b00, pix.row, 8'd0} - {1'b0, h, 7'd0};
	assign ndx      = 22'd0 - dx;
	assign ndy      = 22'd0 - dy;
	assign rsum     = {2'b00, pix.row} + {1'b0, row_off_q};
	assign csum     = {1'b0, w} + {3'b000, col_off_q};
	assign idx_prod = {15'd0, rsum} * {14'd0, csum};
	assign idx_sum  = idx_prod + {17'd0, pix.column} + {17'd0, col_off_q};

	logic  v_s1;
	side_t sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= pix_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1.sx  <= dx[21];
			sd_s1.adx <= dx[21] ? ndx[19:0] : dx[19:0];
			sd_s1.sy  <= dy[21];
			sd_s1.ady <= dy[21] ? ndy[19:0] : dy[19:0];
			sd_s1.idx <= idx_sum[26:0];
		end
	end

	// ---------------- s2: R^2 + dx^2
	logic [47:0] rsq;
	logic [39:0] asq;
	assign rsq = {24'd0, radius_q} * {24'd0, radius_q};
	assign asq = {20'd0, sd_s1.adx} * {20'd0, sd_s1.adx};

	logic        v_s2;
	side_t       sd_s2;
	logic [48:0] rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s2  <= sd_s1;
			rad_s2 <= {1'b0, rsq} + {9'd0, asq};
		end
	end

	// ---------------- s3 group: square root
	logic   [SQ_ST-1:0] v_s3;
	side_t  sd_s3 [SQ_ST];
	sq_st_t sq_s3 [SQ_ST];

	for (genvar gi = 0; gi < SQ_ST; gi++) begin : g_sqrt
		sq_st_t st_in, st_nx;
		side_t  sd_in;
		logic   vl_in;
		if (gi == 0) begin : g_head
			assign st_in = '{v: {1'b0, rad_s2}, rem: '0, q: '0};
			assign sd_in = sd_s2;
			assign vl_in = v_s2;
		end else begin : g_body
			assign st_in = sq_s3[gi-1];
			assign sd_in = sd_s3[gi-1];
			assign vl_in = v_s3[gi-1];
		end
		always_comb begin
			st_nx = st_in;
			for (int j = 0; j < SQ_PER; j++) begin
				if (gi * SQ_PER + j < SQ_N) st_nx = sqrt_step(st_nx);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s3[gi] <= 1'b0;
			else if (adv) v_s3[gi] <= vl_in;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s3[gi] <= st_nx;
				sd_s3[gi] <= sd_in;
			end
		end
	end

	// ---------------- s4 group: k = (s << 16) / R
	logic   [DIV_ST-1:0] v_s4;
	side_t  sd_s4 [DIV_ST];
	dv_st_t dv_s4 [DIV_ST];

	for (genvar gi = 0; gi < DIV_ST; gi++) begin : g_div
		dv_st_t st_in, st_nx;
		side_t  sd_in;
		logic   vl_in;
		if (gi == 0) begin : g_head
			assign st_in = '{num: {sq_s3[SQ_ST-1].q, 16'd0}, rem: '0, q: '0};
			assign sd_in = sd_s3[SQ_ST-1];
			assign vl_in = v_s3[SQ_ST-1];
		end else begin : g_body
			assign st_in = dv_s4[gi-1];
			assign sd_in = sd_s4[gi-1];
			assign vl_in = v_s4[gi-1];
		end
		always_comb begin
			st_nx = st_in;
			for (int j = 0; j < DIV_PER; j++) begin
				if (gi * DIV_PER + j < DIV_N) st_nx = div_step(st_nx, radius_q);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s4[gi] <= 1'b0;
			else if (adv) v_s4[gi] <= vl_in;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s4[gi] <= st_nx;
				sd_s4[gi] <= sd_in;
			end
		end
	end

	// ---------------- s5: partial products of |d| * k
	logic [40:0] k;
	assign k = dv_s4[DIV_ST-1].q;

	logic        v_s5;
	side_t       sd_s5;
	logic [40:0] plx_s5, ply_s5;
	logic [39:0] phx_s5, phy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4[DIV_ST-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s5  <= sd_s4[DIV_ST-1];
			plx_s5 <= {21'd0, sd_s4[DIV_ST-1].adx} * {20'd0, k[20:0]};
			ply_s5 <= {21'd0, sd_s4[DIV_ST-1].ady} * {20'd0, k[20:0]};
			phx_s5 <= {20'd0, sd_s4[DIV_ST-1].adx} * {20'd0, k[40:21]};
			phy_s5 <= {20'd0, sd_s4[DIV_ST-1].ady} * {20'd0, k[40:21]};
		end
	end

	// ---------------- s6: combine, drop 16 fraction bits
	logic [60:0] sumx, sumy;
	assign sumx = {phx_s5, 21'd0} + {20'd0, plx_s5};
	assign sumy = {phy_s5, 21'd0} + {20'd0, ply_s5};

	logic        v_s6;
	side_t       sd_s6;
	logic [44:0] px_s6, py_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s6 <= sd_s5;
			px_s6 <= sumx[60:16];
			py_s6 <= sumy[60:16];
		end
	end

	// ---------------- s7: apply sign, add half size
	logic [46:0] half_w, half_h;
	assign half_w = {26'd0, w, 7'd0};
	assign half_h = {26'd0, h, 7'd0};

	logic        v_s7;
	side_t       sd_s7;
	logic [46:0] x_s7, y_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s7 <= sd_s6;
			x_s7  <= sd_s6.sx ? half_w - {2'b00, px_s6} : half_w + {2'b00, px_s6};
			y_s7  <= sd_s6.sy ? half_h - {2'b00, py_s6} : half_h + {2'b00, py_s6};
		end
	end

	// ---------------- s8: bounds test, output word
	logic [13:0] wm1, hm1;
	logic        inb;
	assign wm1 = w - 14'd1;
	assign hm1 = h - 14'd1;
	// x >= 0 and x < (W-1)*256; a zero size gives an empty area
	assign inb = (radius_q != '0) && (w != '0) && (h != '0)
		&& !x_s7[46] && !y_s7[46]
		&& (x_s7[45:0] < {24'd0, wm1, 8'd0})
		&& (y_s7[45:0] < {24'd0, hm1, 8'd0});

	map_t map_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			map_s8.in_bounds   <= inb;
			map_s8.source_x_q8 <= inb ? x_s7[19:0] : 20'd0;
			map_s8.source_y_q8 <= inb ? y_s7[19:0] : 20'd0;
			map_s8.dest_index  <= sd_s7.idx;
		end
	end

	assign map_valid = v_s8;
	assign map       = map_s8;

endmodule

// ===== rtl/core/cwcm_checker.sv =====
// ----------------------------------------------------------------------------
// cwcm_checker
// Port-level checks of the cylindrical warp map, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cwcm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pix_valid,
	input logic           pix_ready,
	input cwcm_pkg::pix_t pix,
	input logic           map_valid,
	input logic           map_ready,
	input cwcm_pkg::map_t map
);
	import cwcm_pkg::*;

	// held output word stays put
	`CHK_NEXT(a_map_hold, map_valid && !map_ready, map_valid && $stable(map), "map word changed while stalled")

	// out-of-bounds words carry zero coordinates
	`CHK_PROP(a_oob_zero, map_valid && !map.in_bounds |-> map.source_x_q8 == 20'd0 && map.source_y_q8 == 20'd0, "nonzero coordinate on out-of-bounds word")

	// an empty output slot never blocks the input
	`CHK_PROP(a_ready_empty, !map_valid |-> pix_ready, "input blocked with output empty")

	// a taken output word frees the pipe in the same cycle
	`CHK_PROP(a_ready_take, map_valid && map_ready |-> pix_ready, "input blocked while output taken")

endmodule

bind cylindrical_warp_coord_map cwcm_checker u_cwcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.pix       (pix),
	.map_valid (map_valid),
	.map_ready (map_ready),
	.map       (map)
);
